// File: rtl/telemetry_limit_persistence_alarm_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the telemetry limit persistence alarm
// Shared concurrent assertion forms, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef TELEMETRY_LIMIT_PERSISTENCE_ALARM_MACROS_SVH
`define TELEMETRY_LIMIT_PERSISTENCE_ALARM_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define TLPA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tlpa assertion failed");

// consequent must hold in the cycle after the antecedent
`define TLPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlpa assertion failed");

`endif

// File: rtl/tlpa_pkg.sv
// ---------------------------------------------------------------------------
// tlpa_pkg
// Constants and types for the telemetry limit persistence alarm
// ---------------------------------------------------------------------------
package tlpa_pkg;

  // readings in a run, current one included (range 2 to 8)
  localparam int RUN_LENGTH = 3;
  // earlier readings held per stream
  localparam int HIST_DEPTH = RUN_LENGTH - 1;
  localparam int SEEN_W     = $clog2(RUN_LENGTH);

  // two satellites times two modes
  localparam int STREAMS  = 4;
  localparam int STREAM_W = 2;

  // field widths
  localparam int SAT_W   = 16;
  localparam int TIME_W  = 32;
  localparam int VAL_W   = 24;
  localparam int WIN_W   = 16;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SECONDS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SATELLITE_ID  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_SATELLITE_ID = 2'd2;

  // register reset values
  localparam logic [WIN_W-1:0] WINDOW_RESET     = 16'd300;
  localparam logic [SAT_W-1:0] FIRST_SAT_RESET  = 16'd1000;
  localparam logic [SAT_W-1:0] SECOND_SAT_RESET = 16'd1001;

  // component modes
  localparam logic MODE_THERMOSTAT = 1'b0;
  localparam logic MODE_BATTERY    = 1'b1;

  typedef logic signed [VAL_W-1:0] value_t;

  // limit check for one stored or current value
  function automatic logic violates(input logic mode, input value_t raw,
                                    input value_t hi, input value_t lo);
    logic v;
    v = (mode == MODE_BATTERY) ? (raw < lo) : (raw > hi);
    return v;
  endfunction

endpackage

// File: rtl/tlpa_if.sv
// ---------------------------------------------------------------------------
// tlpa channel interfaces
// Reading channel and result channel, valid/ready handshake
// ---------------------------------------------------------------------------
interface tlpa_reading_if;
  logic                                valid;
  logic                                ready;
  logic [tlpa_pkg::SAT_W-1:0]          sat_id;
  logic                                mode;
  logic [tlpa_pkg::TIME_W-1:0]         timestamp_s;
  logic signed [tlpa_pkg::VAL_W-1:0]   raw_reading;
  logic signed [tlpa_pkg::VAL_W-1:0]   red_high_limit;
  logic signed [tlpa_pkg::VAL_W-1:0]   red_low_limit;

  modport source (output valid, output sat_id, output mode, output timestamp_s,
                  output raw_reading, output red_high_limit, output red_low_limit,
                  input ready);
  modport sink (input valid, input sat_id, input mode, input timestamp_s,
                input raw_reading, input red_high_limit, input red_low_limit,
                output ready);
endinterface

interface tlpa_result_if;
  logic                          valid;
  logic                          ready;
  logic                          alert;
  logic [tlpa_pkg::SAT_W-1:0]    alert_satellite;
  logic                          alert_mode;
  logic [tlpa_pkg::TIME_W-1:0]   alert_time;

  modport source (output valid, output alert, output alert_satellite, output alert_mode,
                  output alert_time, input ready);
  modport sink (input valid, input alert, input alert_satellite, input alert_mode,
                input alert_time, output ready);
endinterface

// File: rtl/telemetry_limit_persistence_alarm.sv
// ---------------------------------------------------------------------------
// telemetry_limit_persistence_alarm
// Raises an alert when a run of limit violations in one stream falls inside
// the time window; four streams (two satellites times two modes)
// ---------------------------------------------------------------------------
//  channel   direction  handshake      payload
//  reading   sink       valid/ready    sat_id, mode, timestamp_s, raw, limits
//  result    source     valid/ready    alert, alert_satellite, alert_mode, alert_time
//  cfg       sink       cfg_wr_en      cfg_index, cfg_data
//
//  one item per cycle while results are taken; input register, then result register
//  the input register feeds one pass of compares against the stream history,
//  which is updated in the same cycle the item moves to the result register
//  reset (rst, synchronous) resets config registers, clears valid flags and history counts
//  a stalled result holds; the input register still fills behind it
// ---------------------------------------------------------------------------
`include "telemetry_limit_persistence_alarm_macros.svh"

module telemetry_limit_persistence_alarm (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [tlpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tlpa_pkg::CFG_DATA_W-1:0]     cfg_data,
  tlpa_reading_if.sink                        reading,
  tlpa_result_if.source                       result
);

  // configuration registers
  logic [tlpa_pkg::WIN_W-1:0] window_seconds;
  logic [tlpa_pkg::SAT_W-1:0] first_sat_id;
  logic [tlpa_pkg::SAT_W-1:0] second_sat_id;

  // input register
  logic                         s1_valid;
  logic [tlpa_pkg::SAT_W-1:0]   s1_sat;
  logic                         s1_mode;
  logic [tlpa_pkg::TIME_W-1:0]  s1_time;
  tlpa_pkg::value_t             s1_raw;
  tlpa_pkg::value_t             s1_hi;
  tlpa_pkg::value_t             s1_lo;

  // per-stream history, index 0 oldest
  tlpa_pkg::value_t             hist_raw  [tlpa_pkg::STREAMS][tlpa_pkg::HIST_DEPTH];
  logic [tlpa_pkg::TIME_W-1:0]  hist_time [tlpa_pkg::STREAMS][tlpa_pkg::HIST_DEPTH];
  logic [tlpa_pkg::STREAMS-1:0][tlpa_pkg::SEEN_W-1:0] seen;

  // result register
  logic                         res_valid;
  logic                         res_alert;
  logic [tlpa_pkg::SAT_W-1:0]   res_sat;
  logic                         res_mode;
  logic [tlpa_pkg::TIME_W-1:0]  res_time;

  logic                          s1_advance;
  logic                          s1_hit;
  logic [tlpa_pkg::STREAM_W-1:0] s1_stream;
  logic                          hist_full;
  logic                          all_violate;
  logic signed [tlpa_pkg::TIME_W:0] span;
  logic                          alert_next;

  // handshake
  assign s1_advance    = s1_valid && (!res_valid || result.ready);
  assign reading.ready = !s1_valid || s1_advance;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_seconds <= tlpa_pkg::WINDOW_RESET;
      first_sat_id   <= tlpa_pkg::FIRST_SAT_RESET;
      second_sat_id  <= tlpa_pkg::SECOND_SAT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tlpa_pkg::CFG_WINDOW_SECONDS:      window_seconds <= cfg_data;
        tlpa_pkg::CFG_FIRST_SATELLITE_ID:  first_sat_id   <= cfg_data;
        tlpa_pkg::CFG_SECOND_SATELLITE_ID: second_sat_id  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (reading.ready) begin
      s1_valid <= reading.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (reading.valid && reading.ready) begin
      s1_sat  <= reading.sat_id;
      s1_mode <= reading.mode;
      s1_time <= reading.timestamp_s;
      s1_raw  <= reading.raw_reading;
      s1_hi   <= reading.red_high_limit;
      s1_lo   <= reading.red_low_limit;
    end
  end

  // stream lookup, first satellite wins when both ids match
  always_comb begin
    s1_hit    = 1'b1;
    s1_stream = {1'b0, s1_mode};
    if (s1_sat == first_sat_id) begin
      s1_stream = {1'b0, s1_mode};
    end else if (s1_sat == second_sat_id) begin
      s1_stream = {1'b1, s1_mode};
    end else begin
      s1_hit = 1'b0;
    end
  end

  // run check against the current limits
  always_comb begin
    all_violate = tlpa_pkg::violates(s1_mode, s1_raw, s1_hi, s1_lo);
    for (int i = 0; i < tlpa_pkg::HIST_DEPTH; i++) begin
      all_violate = all_violate &&
                    tlpa_pkg::violates(s1_mode, hist_raw[s1_stream][i], s1_hi, s1_lo);
    end
    hist_full  = (seen[s1_stream] == tlpa_pkg::SEEN_W'(tlpa_pkg::HIST_DEPTH));
    span       = $signed({1'b0, s1_time}) - $signed({1'b0, hist_time[s1_stream][0]});
    alert_next = s1_hit && hist_full && all_violate &&
                 (span < $signed({{(tlpa_pkg::TIME_W + 1 - tlpa_pkg::WIN_W){1'b0}},
                                  window_seconds}));
  end

  // history shift for the addressed stream
  always_ff @(posedge clk) begin
    if (s1_advance && s1_hit) begin
      for (int i = 0; i < tlpa_pkg::HIST_DEPTH - 1; i++) begin
        hist_raw[s1_stream][i]  <= hist_raw[s1_stream][i + 1];
        hist_time[s1_stream][i] <= hist_time[s1_stream][i + 1];
      end
      hist_raw[s1_stream][tlpa_pkg::HIST_DEPTH - 1]  <= s1_raw;
      hist_time[s1_stream][tlpa_pkg::HIST_DEPTH - 1] <= s1_time;
    end
  end

  // fill count, saturating once the history is full
  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (s1_advance && s1_hit && !hist_full) begin
      seen[s1_stream] <= seen[s1_stream] + tlpa_pkg::SEEN_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      res_alert <= alert_next;
      res_sat   <= s1_sat;
      res_mode  <= s1_mode;
      res_time  <= s1_time;
    end
  end

  assign result.valid           = res_valid;
  assign result.alert           = res_alert;
  assign result.alert_satellite = res_sat;
  assign result.alert_mode      = res_mode;
  assign result.alert_time      = res_time;

  // checks
  `TLPA_ASSERT_NEXT(a_unknown_keeps_counts, s1_advance && !s1_hit, seen == $past(seen))
  `TLPA_ASSERT_NOW(a_alert_needs_full_history, alert_next, hist_full && s1_hit)
  `TLPA_ASSERT_NEXT(a_advance_fills_result, s1_advance, res_valid)
  `TLPA_ASSERT_NEXT(a_accept_fills_input, reading.valid && reading.ready, s1_valid)

endmodule

// File: dv/telemetry_alarm_checker.sv
// ---------------------------------------------------------------------------
// telemetry_alarm_checker
// Watches the reading, result and register write ports of the persistence
// alarm, keeps its own copy of the per-stream history and registers, works
// out the expected result of every accepted reading and compares each
// accepted result, field by field, with the oldest expected one
// ---------------------------------------------------------------------------
module telemetry_alarm_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [tlpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlpa_pkg::CFG_DATA_W-1:0] cfg_data,
  tlpa_reading_if                         reading,
  tlpa_result_if                          result,
  output int                              pending,
  output int                              fail_count
);
  import tlpa_pkg::*;

  typedef struct packed {
    logic              alert;
    logic [SAT_W-1:0]  sat;
    logic              mode;
    logic [TIME_W-1:0] stamp;
  } alarm_t;

  // expected results, oldest first
  alarm_t alarm_q[$];

  // register copies
  logic [WIN_W-1:0] window_s;
  logic [SAT_W-1:0] sat_slot0;
  logic [SAT_W-1:0] sat_slot1;

  // per-stream history, index 0 the most recent earlier reading
  value_t            hist_raw  [STREAMS][HIST_DEPTH];
  logic [TIME_W-1:0] hist_time [STREAMS][HIST_DEPTH];
  int                hist_count[STREAMS];

  int results_seen;

  // strict red check: high limit for thermostat, low limit for battery
  function automatic logic in_red(input logic mode, input value_t raw,
                                  input value_t hi, input value_t lo);
    logic red;
    if (mode == MODE_BATTERY) begin
      red = (raw < lo);
    end else begin
      red = (raw > hi);
    end
    return red;
  endfunction

  // expected result of one reading; moves the stream history on
  task automatic predict_alarm(input logic [SAT_W-1:0] sat, input logic mode,
                               input logic [TIME_W-1:0] now, input value_t raw,
                               input value_t hi, input value_t lo,
                               output alarm_t res);
    int     s;
    int     k;
    logic   hit;
    longint span;
    res.alert = 1'b0;
    res.sat   = sat;
    res.mode  = mode;
    res.stamp = now;
    s = -1;
    if (sat == sat_slot0) begin
      s = int'(mode);
    end else if (sat == sat_slot1) begin
      s = 2 + int'(mode);
    end
    if (s >= 0) begin
      // full run held: every reading red and the span under the window
      if (hist_count[s] >= HIST_DEPTH) begin
        hit = in_red(mode, raw, hi, lo);
        for (k = 0; k < HIST_DEPTH; k++) begin
          hit = hit & in_red(mode, hist_raw[s][k], hi, lo);
        end
        span = longint'({32'd0, now}) - longint'({32'd0, hist_time[s][HIST_DEPTH-1]});
        res.alert = hit && (span < longint'({48'd0, window_s}));
      end
      // shift history
      for (k = HIST_DEPTH - 1; k > 0; k--) begin
        hist_raw[s][k]  = hist_raw[s][k-1];
        hist_time[s][k] = hist_time[s][k-1];
      end
      hist_raw[s][0]  = raw;
      hist_time[s][0] = now;
      if (hist_count[s] < HIST_DEPTH) begin
        hist_count[s] = hist_count[s] + 1;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input longint got,
                                 input longint want);
    $display("%0t: result %0d: %s got %0h expected %0h", $realtime, results_seen,
             what, got, want);
    fail_count = fail_count + 1;
  endtask

  // sample the ports at the rising edge
  always @(posedge clk) begin
    alarm_t want;
    alarm_t got;
    if (rst) begin
      window_s  = WINDOW_RESET;
      sat_slot0 = FIRST_SAT_RESET;
      sat_slot1 = SECOND_SAT_RESET;
      for (int s = 0; s < STREAMS; s++) begin
        hist_count[s] = 0;
        for (int k = 0; k < HIST_DEPTH; k++) begin
          hist_raw[s][k]  = '0;
          hist_time[s][k] = '0;
        end
      end
      alarm_q.delete();
      results_seen = 0;
      fail_count   = 0;
      pending     <= 0;
    end else begin
      // register writes
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_WINDOW_SECONDS:      window_s  = cfg_data;
          CFG_FIRST_SATELLITE_ID:  sat_slot0 = cfg_data;
          CFG_SECOND_SATELLITE_ID: sat_slot1 = cfg_data;
          default: ;
        endcase
      end
      // accepted reading
      if (reading.valid && reading.ready) begin
        predict_alarm(reading.sat_id, reading.mode, reading.timestamp_s,
                      reading.raw_reading, reading.red_high_limit,
                      reading.red_low_limit, want);
        alarm_q.push_back(want);
      end
      // accepted result
      if (result.valid && result.ready) begin
        got.alert = result.alert;
        got.sat   = result.alert_satellite;
        got.mode  = result.alert_mode;
        got.stamp = result.alert_time;
        if (alarm_q.size() == 0) begin
          report_mismatch("unexpected item, alert", longint'(got.alert), longint'(0));
        end else begin
          want = alarm_q.pop_front();
          if (got.alert !== want.alert)
            report_mismatch("alert", longint'(got.alert), longint'(want.alert));
          if (got.sat !== want.sat)
            report_mismatch("alert_satellite", longint'(got.sat), longint'(want.sat));
          if (got.mode !== want.mode)
            report_mismatch("alert_mode", longint'(got.mode), longint'(want.mode));
          if (got.stamp !== want.stamp)
            report_mismatch("alert_time", longint'(got.stamp), longint'(want.stamp));
        end
        results_seen = results_seen + 1;
      end
      pending <= alarm_q.size();
    end
  end

endmodule

// File: dv/tb_telemetry_limit_persistence_alarm.sv
// ---------------------------------------------------------------------------
// tb_telemetry_limit_persistence_alarm
// Drives readings and register writes into the persistence alarm: a short
// directed run over the limit, window and satellite corner cases, then
// random phases over several register settings with random idling on both
// sides, one long result stall and one drain pause; the checker predicts
// and compares, this module gives the verdict
// ---------------------------------------------------------------------------
module tb_telemetry_limit_persistence_alarm;
  import tlpa_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
  localparam value_t VAL_MAX      = 24'sh7FFFFF;
  localparam value_t VAL_MIN      = 24'sh800000;
  localparam int     PHASES       = 6;
  localparam int     PHASE_ITEMS  = 205;
  localparam int     IDLE_PCT     = 36;
  localparam int     HOLD_CYCLES  = 48;
  localparam int     DRAIN_CYCLES = 6;
  localparam int     QUIET_LIMIT  = 2000;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  tlpa_reading_if rd();
  tlpa_result_if  res();

  int pending;
  int fail_count;
  int quiet;

  // stimulus controls shared with the ready process
  bit idling_on   = 1'b1;
  int hold_asked  = 0;
  int hold_served = 0;

  // register copies and per-stream stimulus state
  logic [WIN_W-1:0]  win_now = WINDOW_RESET;
  logic [SAT_W-1:0]  id_a    = FIRST_SAT_RESET;
  logic [SAT_W-1:0]  id_b    = SECOND_SAT_RESET;
  logic [TIME_W-1:0] stream_clock[STREAMS];
  int                limit_base[STREAMS];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  telemetry_limit_persistence_alarm u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .reading   (rd),
    .result    (res)
  );

  telemetry_alarm_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .reading    (rd),
    .result     (res),
    .pending    (pending),
    .fail_count (fail_count)
  );

  // result side: random stalls, plus a long counted hold on request
  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        res.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        res.ready = !idling_on || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // watchdog on cycles with work outstanding and nothing moving
  always @(posedge clk) begin
    if (rst) begin
      quiet <= 0;
    end else if ((rd.valid && rd.ready) || (res.valid && res.ready)) begin
      quiet <= 0;
    end else if (rd.valid || pending != 0) begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // offer one item and hold it until accepted; called and returns at negedge
  task automatic send_reading(input logic [SAT_W-1:0] sat, input logic mode,
                              input logic [TIME_W-1:0] stamp, input value_t raw,
                              input value_t hi, input value_t lo);
    while (idling_on && $urandom_range(99) < IDLE_PCT) begin
      rd.valid = 1'b0;
      @(negedge clk);
    end
    rd.valid          = 1'b1;
    rd.sat_id         = sat;
    rd.mode           = mode;
    rd.timestamp_s    = stamp;
    rd.raw_reading    = raw;
    rd.red_high_limit = hi;
    rd.red_low_limit  = lo;
    @(posedge clk);
    while (!rd.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // stop offering and wait for every expected result, then let the pipe settle
  task automatic drain();
    rd.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_wr_en = 1'b1;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    case (idx)
      CFG_WINDOW_SECONDS:      win_now = data;
      CFG_FIRST_SATELLITE_ID:  id_a    = data;
      CFG_SECOND_SATELLITE_ID: id_b    = data;
      default: ;
    endcase
  endtask

  // mostly well-formed runs near a per-stream limit, some noise
  task automatic random_reading();
    int                s;
    int                roll;
    int                lim;
    int                margin;
    logic [SAT_W-1:0]  sat;
    logic              mode;
    value_t            raw;
    value_t            hi;
    value_t            lo;
    s    = $urandom_range(3);
    mode = s[0];
    sat  = (s >= 2) ? id_b : id_a;
    if ($urandom_range(99) < 12) sat = SAT_W'($urandom);
    // time: mostly forward in steps of up to about half the window
    roll = $urandom_range(99);
    if (roll < 4) begin
      stream_clock[s] = $urandom;
    end else if (roll < 9) begin
      stream_clock[s] = stream_clock[s] - $urandom_range(1, 50);
    end else if (win_now == 0) begin
      stream_clock[s] = stream_clock[s] + $urandom_range(0, 2);
    end else begin
      stream_clock[s] = stream_clock[s] + $urandom_range(0, int'(win_now) / 2 + 1);
    end
    // values
    if ($urandom_range(99) < 10) begin
      raw = value_t'($urandom);
      hi  = value_t'($urandom);
      lo  = value_t'($urandom);
    end else begin
      lim = limit_base[s] + int'($urandom_range(0, 8)) - 4;
      if ($urandom_range(99) < 75) begin
        margin = int'($urandom_range(1, 200));
      end else begin
        margin = -int'($urandom_range(0, 200));
      end
      if (mode == MODE_BATTERY) begin
        raw = value_t'(lim - margin);
        lo  = value_t'(lim);
        hi  = value_t'($urandom);
      end else begin
        raw = value_t'(lim + margin);
        hi  = value_t'(lim);
        lo  = value_t'($urandom);
      end
    end
    send_reading(sat, mode, stream_clock[s], raw, hi, lo);
  endtask

  // main sequence
  initial begin
    logic [WIN_W-1:0] win;
    logic [SAT_W-1:0] a;
    logic [SAT_W-1:0] b;
    rd.valid          = 1'b0;
    rd.sat_id         = '0;
    rd.mode           = 1'b0;
    rd.timestamp_s    = '0;
    rd.raw_reading    = '0;
    rd.red_high_limit = '0;
    rd.red_low_limit  = '0;
    for (int s = 0; s < STREAMS; s++) begin
      stream_clock[s] = '0;
      limit_base[s]   = 0;
    end
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // thermostat run, strict compare, stored values against the new limit
    send_reading(16'd1000, MODE_THERMOSTAT, 32'd10, 24'sd100, 24'sd50, 24'sd0);
    send_reading(16'd1000, MODE_THERMOSTAT, 32'd20, 24'sd200, 24'sd50, 24'sd0);
    send_reading(16'd1000, MODE_THERMOSTAT, 32'd30, 24'sd51, 24'sd50, 24'sd0);
    send_reading(16'd1000, MODE_THERMOSTAT, 32'd40, 24'sd50, 24'sd50, 24'sd0);
    // unknown satellites leave the history alone
    send_reading(16'h0000, MODE_THERMOSTAT, 32'd41, VAL_MAX, VAL_MIN, VAL_MIN);
    send_reading(16'hFFFF, MODE_BATTERY, 32'd42, VAL_MIN, VAL_MAX, VAL_MAX);
    send_reading(16'd1000, MODE_THERMOSTAT, 32'd50, VAL_MAX, VAL_MIN, VAL_MAX);
    send_reading(16'd1000, MODE_THERMOSTAT, 32'd60, VAL_MAX, VAL_MAX, VAL_MIN);
    // battery at the bottom of the range, time going backwards
    send_reading(16'd1001, MODE_BATTERY, 32'hFFFF_FFFF, VAL_MIN, VAL_MAX, VAL_MIN + 24'sd1);
    send_reading(16'd1001, MODE_BATTERY, 32'd5, VAL_MIN, 24'sd0, VAL_MIN + 24'sd1);
    send_reading(16'd1001, MODE_BATTERY, 32'd0, VAL_MIN, 24'sd0, VAL_MIN + 24'sd1);
    send_reading(16'd1001, MODE_BATTERY, 32'd1, VAL_MIN + 24'sd1, 24'sd0, VAL_MIN + 24'sd1);
    // span just under and exactly at the window
    send_reading(16'd1000, MODE_BATTERY, 32'd1000, -24'sd10, 24'sd0, 24'sd0);
    send_reading(16'd1000, MODE_BATTERY, 32'd1100, -24'sd20, 24'sd0, 24'sd0);
    send_reading(16'd1000, MODE_BATTERY, 32'd1299, -24'sd1, 24'sd0, 24'sd0);
    send_reading(16'd1000, MODE_BATTERY, 32'd1400, -24'sd5, 24'sd0, 24'sd0);
    // raised limit clears earlier violations
    send_reading(16'd1001, MODE_THERMOSTAT, 32'd1, 24'sd10, 24'sd0, 24'sd0);
    send_reading(16'd1001, MODE_THERMOSTAT, 32'd2, 24'sd20, 24'sd0, 24'sd0);
    send_reading(16'd1001, MODE_THERMOSTAT, 32'd3, 24'sd30, 24'sd15, 24'sd0);

    // zero window, both ids equal, write to the unused index
    drain();
    write_register(CFG_UNUSED_INDEX, 16'h0005);
    write_register(CFG_WINDOW_SECONDS, 16'd0);
    write_register(CFG_FIRST_SATELLITE_ID, 16'd7);
    write_register(CFG_SECOND_SATELLITE_ID, 16'd7);
    repeat (3) send_reading(16'd7, MODE_THERMOSTAT, 32'd10, 24'sd5, 24'sd0, 24'sd0);
    send_reading(16'd7, MODE_THERMOSTAT, 32'd9, 24'sd5, 24'sd0, 24'sd0);

    // random phases over several register settings
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      idling_on = 1'b1;
      case (phase)
        0: begin
          win = 16'hFFFF; a = 16'h0000; b = 16'hFFFF;
        end
        1: begin
          win = 16'd1; a = 16'hFFFF; b = 16'h0000;
        end
        2: begin
          win = WIN_W'($urandom_range(1, 2000)); a = SAT_W'($urandom); b = SAT_W'($urandom);
          idling_on = 1'b0;
        end
        3: begin
          win = 16'd0; a = SAT_W'($urandom); b = a;
        end
        4: begin
          win = WINDOW_RESET; a = FIRST_SAT_RESET; b = SECOND_SAT_RESET;
        end
        default: begin
          win = WIN_W'($urandom); a = SAT_W'($urandom); b = SAT_W'($urandom);
        end
      endcase
      write_register(CFG_WINDOW_SECONDS, win);
      write_register(CFG_FIRST_SATELLITE_ID, a);
      write_register(CFG_SECOND_SATELLITE_ID, b);
      for (int s = 0; s < STREAMS; s++) begin
        limit_base[s] = int'($urandom_range(0, 16777215 - 2000)) - 8388608 + 1000;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long result hold while readings keep coming
        if (phase == 4 && n == 50) hold_asked = hold_asked + 1;
        // pause until every result is out
        if (phase == 4 && n == 120) drain();
        random_reading();
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/tlpa_pkg.sv
rtl/tlpa_if.sv
rtl/telemetry_limit_persistence_alarm.sv
dv/telemetry_alarm_checker.sv
dv/tb_telemetry_limit_persistence_alarm.sv
